// ===== src/sdc_pkg.sv =====
`default_nettype none

package sdc_pkg;

    typedef logic [21:0] day_num_t;
    typedef logic [16:0] sec_num_t;

    localparam int FRAC_BITS = 32;

    localparam logic signed [55:0] SERIAL_MIN = 56'(-64'sd657434 * 64'sd4294967296);
    localparam logic signed [55:0] SERIAL_MAX = 56'(64'sd2958465 * 64'sd4294967296);

    localparam logic [16:0] DAY_SECONDS  = 17'd86400;
    localparam logic [48:0] ROUND_HALF   = 49'h0_8000_0000;
    localparam logic [21:0] EPOCH_OFFSET = 22'd693959;
    localparam logic [17:0] DAYS_400Y    = 18'd146097;
    localparam logic [15:0] DAYS_100Y    = 16'd36524;
    localparam logic [10:0] DAYS_4Y      = 11'd1461;
    localparam logic [8:0]  DAYS_1Y      = 9'd365;
    localparam logic [11:0] SEC_HOUR     = 12'd3600;
    localparam logic [5:0]  SEC_MIN      = 6'd60;
    localparam logic [2:0]  WEEK_DAYS    = 3'd7;
    localparam logic [8:0]  LEAP_DAY_IDX = 9'd59;

    localparam logic [13:0] YEARS_ERA  = 14'd400;
    localparam logic [13:0] YEARS_CENT = 14'd100;
    localparam logic [13:0] YEARS_OLY  = 14'd4;

    // Reciprocals scaled by 2^32; the estimate is low by at most one
    localparam logic [31:0] RCP_400Y = 32'((64'd1 << 32) / 64'd146097);
    localparam logic [31:0] RCP_4Y   = 32'((64'd1 << 32) / 64'd1461);
    localparam logic [31:0] RCP_WEEK = 32'((64'd1 << 32) / 64'd7);
    localparam logic [31:0] RCP_HOUR = 32'((64'd1 << 32) / 64'd3600);
    localparam logic [31:0] RCP_MIN  = 32'((64'd1 << 32) / 64'd60);

    localparam logic [8:0] MONTH_START [0:12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

endpackage

`default_nettype wire

// ===== src/serial_date_to_calendar.sv =====
`default_nettype none

// Serial date to Gregorian calendar converter.
// Input channel s_axis: one beat carries a serial date, signed days since
// 1899-12-30 with 32 fraction bits. Output channel m_axis: one beat per input
// beat, in order. m_axis_tuser is 1 when the date lies within the legal range
// (-657434 to 2958465 days); otherwise it is 0 and every field in tdata is 0.
// The time of day is rounded to the nearest second, away from zero, and a
// rounding that reaches a whole day carries into the date.
// The block takes one beat per cycle unless m_axis stalls. Depth is set by the
// constant divisions, each either a reciprocal multiply plus one correction
// (400-year era, 4-year block, weekday, hour, minute) or a compare ladder
// (century, year, month), each split over register stages.
// Every stage holds a valid bit; a stage advances when it is empty or the
// stage after it advances, so a stalled m_axis only halts the stages that
// hold beats and bubbles still fill. s_axis_tready is high whenever the
// output register is empty.
// Reset clears all valid bits; no beat is in flight afterwards.

module serial_date_to_calendar
    import sdc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // [55:0] serial_value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // year[13:0], month[17:14], day_of_month[22:18],
                                             // hour[27:23], minute[33:28], second[39:34],
                                             // weekday[42:40], zero[47:43]
    output logic             m_axis_tuser    // [0] valid_res
);

    localparam int NST = 10;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST:0]   en;

    always_comb
    begin
        en[NST] = m_axis_tready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            en[k] = ~vld_reg[k] | en[k+1];
        end
        vld_next = {vld_reg[NST-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[NST-1];

    // ---------------- stage 1: range check, magnitude
    logic        s1_ok_reg, s1_ok_next;
    logic        s1_neg_reg, s1_neg_next;
    day_num_t    s1_ipart_reg, s1_ipart_next;
    logic [31:0] s1_fpart_reg, s1_fpart_next;
    logic [55:0] mag_c;

    always_comb
    begin
        s1_ok_next    = ($signed(s_axis_tdata) >= SERIAL_MIN) &&
                        ($signed(s_axis_tdata) <= SERIAL_MAX);
        s1_neg_next   = s_axis_tdata[55];
        mag_c         = s_axis_tdata[55] ? (~s_axis_tdata + 56'd1) : s_axis_tdata;
        s1_ipart_next = mag_c[FRAC_BITS+21:FRAC_BITS];
        s1_fpart_next = mag_c[FRAC_BITS-1:0];
    end

    // ---------------- stage 2: fraction to rounded seconds
    logic        s2_ok_reg, s2_neg_reg;
    day_num_t    s2_ipart_reg;
    logic [16:0] s2_secs_reg, s2_secs_next;
    logic [48:0] prod_sec;

    always_comb
    begin
        prod_sec     = 49'(s1_fpart_reg) * 49'(DAY_SECONDS) + ROUND_HALF;
        s2_secs_next = prod_sec[48:32];
    end

    // ---------------- stage 3: day carry, absolute day number
    logic        s3_ok_reg;
    day_num_t    s3_nabs_reg, s3_nabs_next;
    sec_num_t    s3_secs_reg, s3_secs_next;
    day_num_t    ip_c;
    logic        wrap_c;

    always_comb
    begin
        wrap_c       = s2_secs_reg >= DAY_SECONDS;
        ip_c         = wrap_c ? s2_ipart_reg + 22'd1 : s2_ipart_reg;
        s3_secs_next = wrap_c ? s2_secs_reg - DAY_SECONDS : s2_secs_reg;
        s3_nabs_next = s2_neg_reg ? EPOCH_OFFSET - ip_c : EPOCH_OFFSET + ip_c;
    end

    // ---------------- stage 4: quotient estimates for era, weekday, hour
    logic        s4_ok_reg;
    day_num_t    s4_nabs_reg, s4_nm1_reg, s4_nm1_next;
    sec_num_t    s4_secs_reg;
    logic [4:0]  s4_q400_reg, s4_q400_next;
    logic [18:0] s4_qwk_reg, s4_qwk_next;
    logic [4:0]  s4_qhr_reg, s4_qhr_next;
    logic [53:0] p400_c, pwk_c;
    logic [48:0] phr_c;

    always_comb
    begin
        s4_nm1_next  = s3_nabs_reg - 22'd1;
        p400_c       = 54'(s3_nabs_reg) * 54'(RCP_400Y);
        pwk_c        = 54'(s4_nm1_next) * 54'(RCP_WEEK);
        phr_c        = 49'(s3_secs_reg) * 49'(RCP_HOUR);
        s4_q400_next = p400_c[36:32];
        s4_qwk_next  = pwk_c[50:32];
        s4_qhr_next  = phr_c[36:32];
    end

    // ---------------- stage 5: correct era, weekday, hour
    logic        s5_ok_reg;
    logic [17:0] s5_r_reg, s5_r_next;
    logic [4:0]  s5_n400_reg, s5_n400_next;
    logic [2:0]  s5_wday_reg, s5_wday_next;
    logic [4:0]  s5_hour_reg, s5_hour_next;
    logic [11:0] s5_srem_reg, s5_srem_next;
    day_num_t    r400_c, rwk_c;
    sec_num_t    rhr_c;

    always_comb
    begin
        r400_c = s4_nabs_reg - 22'(s4_q400_reg) * 22'(DAYS_400Y);
        s5_n400_next = s4_q400_reg;
        if (r400_c >= 22'(DAYS_400Y))
        begin
            r400_c       = r400_c - 22'(DAYS_400Y);
            s5_n400_next = s4_q400_reg + 5'd1;
        end
        s5_r_next = r400_c[17:0];

        rwk_c = s4_nm1_reg - 22'(s4_qwk_reg) * 22'(WEEK_DAYS);
        if (rwk_c >= 22'(WEEK_DAYS))
        begin
            rwk_c = rwk_c - 22'(WEEK_DAYS);
        end
        s5_wday_next = rwk_c[2:0] + 3'd1;

        rhr_c = s4_secs_reg - 17'(s4_qhr_reg) * 17'(SEC_HOUR);
        s5_hour_next = s4_qhr_reg;
        if (rhr_c >= 17'(SEC_HOUR))
        begin
            rhr_c        = rhr_c - 17'(SEC_HOUR);
            s5_hour_next = s4_qhr_reg + 5'd1;
        end
        s5_srem_next = rhr_c[11:0];
    end

    // ---------------- stage 6: century, minute estimate
    logic        s6_ok_reg;
    logic [4:0]  s6_n400_reg;
    logic [2:0]  s6_wday_reg;
    logic [4:0]  s6_hour_reg;
    logic [11:0] s6_srem_reg;
    logic [1:0]  s6_cent_reg, s6_cent_next;
    logic [15:0] s6_y_reg, s6_y_next;
    logic [5:0]  s6_qmin_reg, s6_qmin_next;
    logic [17:0] rm1_c, cbase_c;
    logic [43:0] pmin_c;

    always_comb
    begin
        rm1_c = s5_r_reg - 18'd1;
        if (s5_r_reg == 18'd0)
        begin
            s6_cent_next = 2'd0;
        end
        else if (rm1_c >= 18'(3) * 18'(DAYS_100Y))
        begin
            s6_cent_next = 2'd3;
        end
        else if (rm1_c >= 18'(2) * 18'(DAYS_100Y))
        begin
            s6_cent_next = 2'd2;
        end
        else if (rm1_c >= 18'(DAYS_100Y))
        begin
            s6_cent_next = 2'd1;
        end
        else
        begin
            s6_cent_next = 2'd0;
        end
        cbase_c   = 18'(s6_cent_next) * 18'(DAYS_100Y);
        s6_y_next = 16'(s5_r_reg - cbase_c);

        pmin_c       = 44'(s5_srem_reg) * 44'(RCP_MIN);
        s6_qmin_next = pmin_c[37:32];
    end

    // ---------------- stage 7: 4-year estimate, correct minute
    logic        s7_ok_reg;
    logic [4:0]  s7_n400_reg;
    logic [2:0]  s7_wday_reg;
    logic [4:0]  s7_hour_reg;
    logic [1:0]  s7_cent_reg;
    logic [15:0] s7_y_reg;
    logic [4:0]  s7_q4_reg, s7_q4_next;
    logic [5:0]  s7_min_reg, s7_min_next;
    logic [5:0]  s7_sec_reg, s7_sec_next;
    logic [47:0] p4_c;
    logic [11:0] rmin_c;

    always_comb
    begin
        p4_c       = 48'(s6_y_reg) * 48'(RCP_4Y);
        s7_q4_next = p4_c[36:32];

        rmin_c      = s6_srem_reg - 12'(s6_qmin_reg) * 12'(SEC_MIN);
        s7_min_next = s6_qmin_reg;
        if (rmin_c >= 12'(SEC_MIN))
        begin
            rmin_c      = rmin_c - 12'(SEC_MIN);
            s7_min_next = s6_qmin_reg + 6'd1;
        end
        s7_sec_next = rmin_c[5:0];
    end

    // ---------------- stage 8: correct 4-year block, leap flag
    logic        s8_ok_reg;
    logic [4:0]  s8_n400_reg;
    logic [2:0]  s8_wday_reg;
    logic [4:0]  s8_hour_reg;
    logic [5:0]  s8_min_reg, s8_sec_reg;
    logic [1:0]  s8_cent_reg;
    logic [4:0]  s8_n4_reg, s8_n4_next;
    logic        s8_leap_reg, s8_leap_next;
    logic [10:0] s8_n4day_reg, s8_n4day_next;
    logic [15:0] r4_c;

    always_comb
    begin
        r4_c       = s7_y_reg - 16'(s7_q4_reg) * 16'(DAYS_4Y);
        s8_n4_next = s7_q4_reg;
        if (r4_c >= 16'(DAYS_4Y))
        begin
            r4_c       = r4_c - 16'(DAYS_4Y);
            s8_n4_next = s7_q4_reg + 5'd1;
        end
        // first block of a non-era century holds no leap year
        s8_leap_next  = !((s7_cent_reg != 2'd0) && (s8_n4_next == 5'd0));
        s8_n4day_next = s8_leap_next ? r4_c[10:0] : r4_c[10:0] - 11'd1;
    end

    // ---------------- stage 9: year within block
    logic        s9_ok_reg;
    logic [4:0]  s9_n400_reg;
    logic [2:0]  s9_wday_reg;
    logic [4:0]  s9_hour_reg;
    logic [5:0]  s9_min_reg, s9_sec_reg;
    logic [1:0]  s9_cent_reg;
    logic [4:0]  s9_n4_reg;
    logic        s9_leap_reg;
    logic [1:0]  s9_yr_reg, s9_yr_next;
    logic [8:0]  s9_d_reg, s9_d_next;
    logic [10:0] src_c, dsub_c;

    always_comb
    begin
        src_c = s8_leap_reg ? s8_n4day_reg - 11'd1 : s8_n4day_reg;
        if (s8_leap_reg && (s8_n4day_reg == 11'd0))
        begin
            s9_yr_next = 2'd0;
        end
        else if (src_c >= 11'(3) * 11'(DAYS_1Y))
        begin
            s9_yr_next = 2'd3;
        end
        else if (src_c >= 11'(2) * 11'(DAYS_1Y))
        begin
            s9_yr_next = 2'd2;
        end
        else if (src_c >= 11'(DAYS_1Y))
        begin
            s9_yr_next = 2'd1;
        end
        else
        begin
            s9_yr_next = 2'd0;
        end
        dsub_c    = src_c - 11'(s9_yr_next) * 11'(DAYS_1Y);
        s9_d_next = (s9_yr_next == 2'd0) ? s8_n4day_reg[8:0] : dsub_c[8:0];
    end

    // ---------------- stage 10: month, day, year; output register
    logic        s10_ok_reg, s10_ok_next;
    logic [13:0] s10_year_reg, s10_year_next;
    logic [3:0]  s10_mon_reg, s10_mon_next;
    logic [4:0]  s10_mday_reg, s10_mday_next;
    logic [4:0]  s10_hour_reg, s10_hour_next;
    logic [5:0]  s10_min_reg, s10_min_next;
    logic [5:0]  s10_sec_reg, s10_sec_next;
    logic [2:0]  s10_wday_reg, s10_wday_next;
    logic        lyear_c;
    logic [8:0]  dd_c, md_c;
    logic [3:0]  mon_c;

    always_comb
    begin
        lyear_c = (s9_yr_reg == 2'd0) && s9_leap_reg;
        dd_c    = s9_d_reg + 9'd1;
        if (lyear_c && (s9_d_reg >= LEAP_DAY_IDX + 9'd1))
        begin
            dd_c = s9_d_reg;
        end
        mon_c = 4'd1;
        for (int m = 1; m < 12; m++)
        begin
            if (dd_c > MONTH_START[m])
            begin
                mon_c = 4'(m + 1);
            end
        end
        md_c = dd_c - MONTH_START[mon_c - 4'd1];
        if (lyear_c && (s9_d_reg == LEAP_DAY_IDX))
        begin
            mon_c = 4'd2;
            md_c  = 9'd29;
        end

        s10_ok_next   = s9_ok_reg;
        s10_year_next = 14'(s9_n400_reg) * YEARS_ERA + 14'(s9_cent_reg) * YEARS_CENT +
                        14'(s9_n4_reg) * YEARS_OLY + 14'(s9_yr_reg);
        s10_mon_next  = mon_c;
        s10_mday_next = md_c[4:0];
        s10_hour_next = s9_hour_reg;
        s10_min_next  = s9_min_reg;
        s10_sec_next  = s9_sec_reg;
        s10_wday_next = s9_wday_reg;
        if (!s9_ok_reg)
        begin
            // out of range: zero every field
            s10_year_next = '0;
            s10_mon_next  = '0;
            s10_mday_next = '0;
            s10_hour_next = '0;
            s10_min_next  = '0;
            s10_sec_next  = '0;
            s10_wday_next = '0;
        end
    end

    // ---------------- payload registers
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_ok_reg    <= s1_ok_next;
            s1_neg_reg   <= s1_neg_next;
            s1_ipart_reg <= s1_ipart_next;
            s1_fpart_reg <= s1_fpart_next;
        end
        if (en[1])
        begin
            s2_ok_reg    <= s1_ok_reg;
            s2_neg_reg   <= s1_neg_reg;
            s2_ipart_reg <= s1_ipart_reg;
            s2_secs_reg  <= s2_secs_next;
        end
        if (en[2])
        begin
            s3_ok_reg   <= s2_ok_reg;
            s3_nabs_reg <= s3_nabs_next;
            s3_secs_reg <= s3_secs_next;
        end
        if (en[3])
        begin
            s4_ok_reg   <= s3_ok_reg;
            s4_nabs_reg <= s3_nabs_reg;
            s4_nm1_reg  <= s4_nm1_next;
            s4_secs_reg <= s3_secs_reg;
            s4_q400_reg <= s4_q400_next;
            s4_qwk_reg  <= s4_qwk_next;
            s4_qhr_reg  <= s4_qhr_next;
        end
        if (en[4])
        begin
            s5_ok_reg   <= s4_ok_reg;
            s5_r_reg    <= s5_r_next;
            s5_n400_reg <= s5_n400_next;
            s5_wday_reg <= s5_wday_next;
            s5_hour_reg <= s5_hour_next;
            s5_srem_reg <= s5_srem_next;
        end
        if (en[5])
        begin
            s6_ok_reg   <= s5_ok_reg;
            s6_n400_reg <= s5_n400_reg;
            s6_wday_reg <= s5_wday_reg;
            s6_hour_reg <= s5_hour_reg;
            s6_srem_reg <= s5_srem_reg;
            s6_cent_reg <= s6_cent_next;
            s6_y_reg    <= s6_y_next;
            s6_qmin_reg <= s6_qmin_next;
        end
        if (en[6])
        begin
            s7_ok_reg   <= s6_ok_reg;
            s7_n400_reg <= s6_n400_reg;
            s7_wday_reg <= s6_wday_reg;
            s7_hour_reg <= s6_hour_reg;
            s7_cent_reg <= s6_cent_reg;
            s7_y_reg    <= s6_y_reg;
            s7_q4_reg   <= s7_q4_next;
            s7_min_reg  <= s7_min_next;
            s7_sec_reg  <= s7_sec_next;
        end
        if (en[7])
        begin
            s8_ok_reg    <= s7_ok_reg;
            s8_n400_reg  <= s7_n400_reg;
            s8_wday_reg  <= s7_wday_reg;
            s8_hour_reg  <= s7_hour_reg;
            s8_min_reg   <= s7_min_reg;
            s8_sec_reg   <= s7_sec_reg;
            s8_cent_reg  <= s7_cent_reg;
            s8_n4_reg    <= s8_n4_next;
            s8_leap_reg  <= s8_leap_next;
            s8_n4day_reg <= s8_n4day_next;
        end
        if (en[8])
        begin
            s9_ok_reg   <= s8_ok_reg;
            s9_n400_reg <= s8_n400_reg;
            s9_wday_reg <= s8_wday_reg;
            s9_hour_reg <= s8_hour_reg;
            s9_min_reg  <= s8_min_reg;
            s9_sec_reg  <= s8_sec_reg;
            s9_cent_reg <= s8_cent_reg;
            s9_n4_reg   <= s8_n4_reg;
            s9_leap_reg <= s8_leap_reg;
            s9_yr_reg   <= s9_yr_next;
            s9_d_reg    <= s9_d_next;
        end
        if (en[9])
        begin
            s10_ok_reg   <= s10_ok_next;
            s10_year_reg <= s10_year_next;
            s10_mon_reg  <= s10_mon_next;
            s10_mday_reg <= s10_mday_next;
            s10_hour_reg <= s10_hour_next;
            s10_min_reg  <= s10_min_next;
            s10_sec_reg  <= s10_sec_next;
            s10_wday_reg <= s10_wday_next;
        end
    end

    assign m_axis_tuser = s10_ok_reg;
    assign m_axis_tdata = {5'd0, s10_wday_reg, s10_sec_reg, s10_min_reg, s10_hour_reg,
                           s10_mday_reg, s10_mon_reg, s10_year_reg};

`ifndef SYNTH
    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register empty");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted beat did not enter first stage");

    a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && s10_ok_reg |->
            (s10_mon_reg >= 4'd1) && (s10_mon_reg <= 4'd12) && (s10_mday_reg != 5'd0) &&
            (s10_wday_reg != 3'd0) && (s10_hour_reg <= 5'd23) &&
            (s10_min_reg <= 6'd59) && (s10_sec_reg <= 6'd59))
        else $error("calendar field out of range");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !s10_ok_reg |-> (m_axis_tdata == 48'd0))
        else $error("out of range result carries non-zero fields");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic        valid;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } calendar_t;

    typedef struct packed {
        logic [55:0] serial;
        logic        typed;
        calendar_t   want;
    } date_case_t;

    localparam longint ONE_DAY      = 64'sd4294967296;
    localparam longint LOW_DAYS     = -64'sd657434;
    localparam longint HIGH_DAYS    = 64'sd2958465;
    localparam longint EPOCH_DAYS   = 64'sd693959;
    localparam longint ERA_DAYS     = 64'sd146097;
    localparam longint CENTURY_DAYS = 64'sd36524;
    localparam longint OLYMPIAD     = 64'sd1461;
    localparam longint YEAR_DAYS    = 64'sd365;
    localparam longint DAY_SECS     = 64'sd86400;
    localparam int     RANDOM_DATES = 1950;
    localparam int     HOLD_CYCLES  = 300;

    localparam int DAYS_BEFORE [0:12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
    };

    localparam calendar_t NO_DATE = '0;

    localparam date_case_t DATE_CASES [0:21] = '{
        '{56'd0, 1'b1, '{1'b1, 14'd1899, 4'd12, 5'd30, 5'd0, 6'd0, 6'd0, 3'd7}},
        '{56'(HIGH_DAYS * ONE_DAY), 1'b1,
          '{1'b1, 14'd9999, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0, 3'd6}},
        '{56'(HIGH_DAYS * ONE_DAY + 1), 1'b1, NO_DATE},
        '{56'(LOW_DAYS * ONE_DAY), 1'b1,
          '{1'b1, 14'd100, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd6}},
        '{56'(LOW_DAYS * ONE_DAY - 1), 1'b1, NO_DATE},
        '{56'h7F_FFFF_FFFF_FFFF, 1'b1, NO_DATE},
        '{56'h80_0000_0000_0000, 1'b1, NO_DATE},
        '{56'hFF_FFFF_FFFF_FFFF, 1'b0, NO_DATE},
        '{56'(-(64'sd5 <<< 30)), 1'b0, NO_DATE},
        '{56'(-(64'sd1 <<< 31)), 1'b0, NO_DATE},
        '{56'(64'sd1 <<< 31), 1'b0, NO_DATE},
        '{56'h00_0000_FFFF_FFFF, 1'b0, NO_DATE},
        '{56'(-64'sd4294967295), 1'b0, NO_DATE},
        '{56'((HIGH_DAYS - 1) * ONE_DAY + 64'sd4294967295), 1'b0, NO_DATE},
        '{56'(-(64'sd657433 * ONE_DAY + 64'sd4294967295)), 1'b0, NO_DATE},
        '{56'(64'sd60 * ONE_DAY), 1'b0, NO_DATE},
        '{56'(64'sd61 * ONE_DAY), 1'b0, NO_DATE},
        '{56'(64'sd1521 * ONE_DAY), 1'b0, NO_DATE},
        '{56'(64'sd36585 * ONE_DAY + 64'sd24855), 1'b0, NO_DATE},
        '{56'(64'sd73110 * ONE_DAY + 64'sd24856), 1'b0, NO_DATE},
        '{56'(-(64'sd36524 * ONE_DAY + 64'sd24856)), 1'b0, NO_DATE},
        '{56'(64'sd36584 * ONE_DAY + 64'sd4294942440), 1'b0, NO_DATE}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;

    calendar_t expected_dates [$];
    int  errors = 0;
    int  dates_sent = 0;
    int  in_range = 0;
    int  out_of_range = 0;
    int  leap_days = 0;
    bit  calm = 1'b0;

    serial_date_to_calendar u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic calendar_t to_calendar(input logic [55:0] serial);
        longint          v, nabs, n400, r, cent, n4, n4day, yr, mon, mday, wday, year;
        longint unsigned mag, ipart, fpart, secs;
        bit              neg, leap4;
        calendar_t       c;
        c = NO_DATE;
        v = longint'($signed(serial));
        if (v > HIGH_DAYS * ONE_DAY || v < LOW_DAYS * ONE_DAY)
            return c;
        neg   = v < 0;
        leap4 = 1'b1;
        mag   = neg ? -v : v;
        ipart = mag >> 32;
        fpart = mag & 64'hFFFF_FFFF;
        // round to the nearest second; a full day carries into the date
        secs  = (fpart * 64'd86400 + 64'h8000_0000) >> 32;
        if (secs >= DAY_SECS)
        begin
            ipart = ipart + 1;
            secs  = secs - DAY_SECS;
        end
        nabs = (neg ? -longint'(ipart) : longint'(ipart)) + EPOCH_DAYS;
        wday = (nabs - 1) % 7 + 1;

        n400 = nabs / ERA_DAYS;
        r    = nabs % ERA_DAYS;
        cent = (r - 1) / CENTURY_DAYS;
        if (cent != 0)
        begin
            r  = (r - 1) % CENTURY_DAYS;
            n4 = (r + 1) / OLYMPIAD;
            if (n4 != 0)
                n4day = (r + 1) % OLYMPIAD;
            else
            begin
                // first block of a non-leap century has no 29 February
                leap4 = 1'b0;
                n4day = r;
            end
        end
        else
        begin
            n4    = r / OLYMPIAD;
            n4day = r % OLYMPIAD;
        end

        if (leap4)
        begin
            yr = (n4day - 1) / YEAR_DAYS;
            if (yr != 0)
                n4day = (n4day - 1) % YEAR_DAYS;
        end
        else
        begin
            yr    = n4day / YEAR_DAYS;
            n4day = n4day % YEAR_DAYS;
        end
        year = n400 * 400 + cent * 100 + n4 * 4 + yr;

        if (yr == 0 && leap4 && n4day == 59)
        begin
            mon  = 2;
            mday = 29;
        end
        else
        begin
            if (yr == 0 && leap4 && n4day >= 60)
                n4day = n4day - 1;
            n4day = n4day + 1;
            mon   = (n4day >> 5) + 1;
            while (mon < 12 && n4day > DAYS_BEFORE[mon])
                mon = mon + 1;
            mday = n4day - DAYS_BEFORE[mon - 1];
        end

        c.valid   = 1'b1;
        c.year    = 14'(year);
        c.month   = 4'(mon);
        c.mday    = 5'(mday);
        c.hour    = 5'(secs / 3600);
        c.minute  = 6'((secs / 60) % 60);
        c.second  = 6'(secs % 60);
        c.weekday = 3'(wday);
        return c;
    endfunction

    task automatic send_date(input logic [55:0] serial, input logic typed,
                             input calendar_t want);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 10)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= serial;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_dates.push_back(typed ? want : to_calendar(serial));
        dates_sent++;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // receiver: random stalls, plus one long hold-off to back the pipeline up
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held && dates_sent >= 400)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= calm || $urandom_range(0, 99) >= 10;
        end
    end

    always @(posedge clk)
    begin
        calendar_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.valid   = m_axis_tuser;
            got.year    = m_axis_tdata[13:0];
            got.month   = m_axis_tdata[17:14];
            got.mday    = m_axis_tdata[22:18];
            got.hour    = m_axis_tdata[27:23];
            got.minute  = m_axis_tdata[33:28];
            got.second  = m_axis_tdata[39:34];
            got.weekday = m_axis_tdata[42:40];
            if (expected_dates.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, tdata=%h tuser=%b",
                         $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                want = expected_dates.pop_front();
                check_field("valid_res", 32'(want.valid), 32'(got.valid));
                check_field("year", 32'(want.year), 32'(got.year));
                check_field("month", 32'(want.month), 32'(got.month));
                check_field("day_of_month", 32'(want.mday), 32'(got.mday));
                check_field("hour", 32'(want.hour), 32'(got.hour));
                check_field("minute", 32'(want.minute), 32'(got.minute));
                check_field("second", 32'(want.second), 32'(got.second));
                check_field("weekday", 32'(want.weekday), 32'(got.weekday));
                check_field("padding", 0, 32'(m_axis_tdata[47:43]));
                if (want.valid)
                    in_range++;
                else
                    out_of_range++;
                if (want.valid && want.month == 4'd2 && want.mday == 5'd29)
                    leap_days++;
            end
        end
    end

    initial
    begin
        longint days, frac, val;
        int unsigned mode;
        wait (rst_n === 1'b1);
        foreach (DATE_CASES[i])
            send_date(DATE_CASES[i].serial, DATE_CASES[i].typed, DATE_CASES[i].want);

        for (int n = 0; n < RANDOM_DATES; n++)
        begin
            calm = (n >= 1000 && n < 1300);
            mode = $urandom_range(0, 99);
            if (mode < 60)
            begin
                // any legal day, any fraction
                days = longint'($urandom_range(0, 32'(HIGH_DAYS - LOW_DAYS))) + LOW_DAYS;
                val  = days * ONE_DAY + longint'($urandom);
            end
            else if (mode < 78)
            begin
                case ($urandom_range(0, 3))
                    0: days = longint'($urandom_range(0, 8)) - 4;
                    1: days = 64'sd1521 + OLYMPIAD * longint'($urandom_range(0, 2000))
                              + longint'($urandom_range(0, 2)) - 1;
                    2: days = LOW_DAYS + longint'($urandom_range(0, 3));
                    default: days = HIGH_DAYS - longint'($urandom_range(0, 3));
                endcase
                // fractions on the rounding and day-carry edges
                case ($urandom_range(0, 5))
                    0: frac = 0;
                    1: frac = 64'sd24855;
                    2: frac = 64'sd24856;
                    3: frac = 64'sd4294967295;
                    4: frac = 64'sd4294967295 - longint'($urandom_range(0, 50000));
                    default: frac = longint'($urandom);
                endcase
                val = days * ONE_DAY + ($urandom_range(0, 1) ? frac : -frac);
            end
            else if (mode < 90)
                val = longint'({$urandom, $urandom});
            else
                val = ($urandom_range(0, 1) ? HIGH_DAYS : LOW_DAYS) * ONE_DAY
                      + longint'($urandom_range(0, 2000)) - 1000;
            send_date(56'(val), 1'b0, NO_DATE);
        end
        calm = 1'b0;

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("converted %0d serial dates: %0d in range, %0d out of range, %0d on 29 Feb",
                 dates_sent, in_range, out_of_range, leap_days);
        $display("covered rounding and day carry at both bounds, random stalls, %0d-cycle hold",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
